// File: rtl/stl_pkg.sv
// Package for the script token lexer: widths, scan modes, character codes,
// token kinds, the keyword table and the token record.
// Depends on nothing; the lexer top level imports it.
package stl_pkg;

    // Widths of the stream position, the kept word prefix and the token fields.
    localparam int OFFSET_BITS      = 16;
    localparam int KEYWORD_MAX_LEN  = 6;
    localparam int KW_BITS          = 8 * KEYWORD_MAX_LEN;
    localparam int FIELD_BITS       = 16;
    localparam int INT_BITS         = 31;
    localparam int KIND_BITS        = 6;
    localparam int IN_TDATA_BITS    = 8;
    localparam int OUT_FIELD_BITS   = KIND_BITS + 3 * FIELD_BITS + INT_BITS + 2;
    localparam int OUT_TDATA_BITS   = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS     = OUT_TDATA_BITS - OUT_FIELD_BITS;
    localparam int NUM_KEYWORDS     = 11;

    localparam logic [INT_BITS-1:0]   INT_MAX   = {INT_BITS{1'b1}};
    localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};

    // Scanner modes; the unused code behaves as idle.
    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_OP      = 3'd1,
        M_SLASH   = 3'd2,
        M_COMMENT = 3'd3,
        M_STRING  = 3'd4,
        M_INT     = 3'd5,
        M_IDENT   = 3'd6
    } t_scan_mode;

    // Character codes.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Token kinds.
    localparam logic [KIND_BITS-1:0] K_LPAREN   = 6'd0;
    localparam logic [KIND_BITS-1:0] K_RPAREN   = 6'd1;
    localparam logic [KIND_BITS-1:0] K_LBRACE   = 6'd2;
    localparam logic [KIND_BITS-1:0] K_RBRACE   = 6'd3;
    localparam logic [KIND_BITS-1:0] K_COMMA    = 6'd4;
    localparam logic [KIND_BITS-1:0] K_SEMI     = 6'd5;
    localparam logic [KIND_BITS-1:0] K_PLUS     = 6'd6;
    localparam logic [KIND_BITS-1:0] K_MINUS    = 6'd7;
    localparam logic [KIND_BITS-1:0] K_STAR     = 6'd8;
    localparam logic [KIND_BITS-1:0] K_SLASH    = 6'd9;
    localparam logic [KIND_BITS-1:0] K_BANG     = 6'd10;
    localparam logic [KIND_BITS-1:0] K_BANG_EQ  = 6'd11;
    localparam logic [KIND_BITS-1:0] K_STRING   = 6'd18;
    localparam logic [KIND_BITS-1:0] K_INT      = 6'd19;
    localparam logic [KIND_BITS-1:0] K_BOOL     = 6'd20;
    localparam logic [KIND_BITS-1:0] K_NULL     = 6'd21;
    localparam logic [KIND_BITS-1:0] K_IDENT    = 6'd22;
    localparam logic [KIND_BITS-1:0] K_KW_FUN   = 6'd23;
    localparam logic [KIND_BITS-1:0] K_EOF      = 6'd34;
    localparam logic [KIND_BITS-1:0] K_ERR_CHAR = 6'd35;
    localparam logic [KIND_BITS-1:0] K_ERR_STR  = 6'd36;

    // Operator codes held while waiting for a possible '='.
    localparam logic [1:0] OP_BANG = 2'd0;
    localparam logic [1:0] OP_EQ   = 2'd1;
    localparam logic [1:0] OP_LT   = 2'd2;
    localparam logic [1:0] OP_GT   = 2'd3;

    // Keyword text, first character in the lowest byte, zero filled.
    localparam logic [KW_BITS-1:0] KW_TEXT [NUM_KEYWORDS] = '{
        KW_BITS'(64'h6E7566),       // fun
        KW_BITS'(64'h6E7275746572), // return
        KW_BITS'(64'h74736E6F63),   // const
        KW_BITS'(64'h726176),       // var
        KW_BITS'(64'h6669),         // if
        KW_BITS'(64'h65736C65),     // else
        KW_BITS'(64'h656C696877),   // while
        KW_BITS'(64'h726F66),       // for
        KW_BITS'(64'h646E61),       // and
        KW_BITS'(64'h726F),         // or
        KW_BITS'(64'h746E697270)    // print
    };
    localparam logic [FIELD_BITS-1:0] KW_LEN [NUM_KEYWORDS] = '{
        16'd3, 16'd6, 16'd5, 16'd3, 16'd2, 16'd4, 16'd5, 16'd3, 16'd3, 16'd2, 16'd5
    };
    localparam logic [KW_BITS-1:0] KW_TRUE  = KW_BITS'(64'h65757274);
    localparam logic [KW_BITS-1:0] KW_FALSE = KW_BITS'(64'h65736C6166);
    localparam logic [KW_BITS-1:0] KW_NULL  = KW_BITS'(64'h6C6C756E);

    // One token as held in the result register.
    typedef struct packed {
        logic                  last;
        logic                  failed;
        logic                  bval;
        logic [INT_BITS-1:0]   ival;
        logic [FIELD_BITS-1:0] line;
        logic [FIELD_BITS-1:0] len;
        logic [FIELD_BITS-1:0] start;
        logic [KIND_BITS-1:0]  kind;
    } t_token;

    // Classify a finished word from its kept prefix and full length.
    function automatic logic [KIND_BITS-1:0] word_kind(
        input logic [KW_BITS-1:0]    prefix,
        input logic [FIELD_BITS-1:0] len
    );
        logic [KIND_BITS-1:0] kind;
        kind = K_IDENT;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (len == KW_LEN[k] && prefix == KW_TEXT[k]) begin
                kind = KIND_BITS'(int'(K_KW_FUN) + k);
            end
        end
        if (len == 16'd4 && prefix == KW_TRUE) begin
            kind = K_BOOL;
        end
        if (len == 16'd5 && prefix == KW_FALSE) begin
            kind = K_BOOL;
        end
        if (len == 16'd4 && prefix == KW_NULL) begin
            kind = K_NULL;
        end
        return kind;
    endfunction

endpackage

// File: rtl/script_token_lexer_unit.sv
// Top level of the script token lexer: input register, scanner state and
// a two-token result register on stream channels.
// Depends on stl_pkg.
//
// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata: char_code[7:0]; tuser: end_of_input
// m_axis    out        tdata: kind, start, length, line, int value, bool, failed;
//                      tlast: last token caused by the source item
//
// One source item is accepted per cycle while the result register has
// room. An item waits in the input register; its combinational scan
// writes the result register, which offers its tokens. An item causing
// two tokens keeps the result register busy for two output transactions,
// which holds the next item in the input register until the first token
// is taken. Reset is synchronous and starts a fresh stream at line 1,
// offset 0; a stalled output holds its token; the input register fills.
module script_token_lexer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // char_code[7:0]
    input  logic [stl_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
    // end_of_input
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // token_kind[5:0], token_start[21:6], token_length[37:22],
    // line_number[53:38], int_value[84:54], bool_flag[85],
    // stream_failed[86], zero fill[87]
    output logic [stl_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    output logic                                m_axis_tlast
);
    import stl_pkg::*;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eoi;

    // Scanner state.
    t_scan_mode              r_mode, n_mode;
    logic [1:0]              r_pend, n_pend;
    logic [OFFSET_BITS-1:0]  r_lex_start, n_lex_start;
    logic [FIELD_BITS-1:0]   r_lex_len, n_lex_len;
    logic [INT_BITS-1:0]     r_acc, n_acc;
    logic [FIELD_BITS-1:0]   r_line, n_line;
    logic [KW_BITS-1:0]      r_prefix, n_prefix;
    logic                    r_err, n_err;
    logic [OFFSET_BITS-1:0]  r_offset, n_offset;

    // Result register.
    logic [1:0] r_res_cnt;
    t_token     r_res [2];

    // Scan results.
    logic       proc_fire;
    logic       take;
    logic       f_v, s_v;
    t_token     f_tok, s_tok, t0, t1;
    logic [1:0] ntok;

    // Helper values of the scan.
    logic                  is_blank, is_digit, is_word_start, is_word_char;
    logic [3:0]            digit;
    logic [INT_BITS+3:0]   acc_x10;
    logic [FIELD_BITS-1:0] len_inc;
    logic [FIELD_BITS-1:0] line_inc;
    logic                  do_flush, do_idle;
    logic                  fl_v;
    t_token                fl_tok;
    logic                  id_v;
    t_token                id_tok;

    // Handshakes.
    assign take          = m_axis_tvalid && m_axis_tready;
    assign proc_fire     = r_in_valid &&
                           (r_res_cnt == 2'd0 || (r_res_cnt == 2'd1 && m_axis_tready));
    assign s_axis_tready = !r_in_valid || proc_fire;

    // Input register: a transaction is held until the scanner takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_char <= s_axis_tdata[7:0];
            r_in_eoi  <= s_axis_tuser;
        end
    end

    // Character classes of the registered byte.
    assign is_blank      = (r_in_char == CH_SPACE) || (r_in_char == CH_TAB);
    assign is_digit      = r_in_char inside {[CH_0:CH_9]};
    assign is_word_start = (r_in_char inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]}) ||
                           (r_in_char == CH_UNDER);
    assign is_word_char  = is_word_start || is_digit;
    assign digit         = 4'(r_in_char - CH_0);
    assign acc_x10       = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) +
                           {{(INT_BITS){1'b0}}, digit};
    assign len_inc       = (r_lex_len == FIELD_MAX) ? r_lex_len : r_lex_len + 16'd1;
    assign line_inc      = (r_line == FIELD_MAX) ? r_line : r_line + 16'd1;

    // Token that the pending lexeme gives when something ends it.
    always_comb begin
        fl_v        = 1'b0;
        fl_tok      = '0;
        fl_tok.start = 16'(r_lex_start);
        fl_tok.len   = r_lex_len;
        fl_tok.line  = r_line;
        case (r_mode)
            M_OP: begin
                fl_v        = 1'b1;
                fl_tok.kind = K_BANG + {3'b0, r_pend, 1'b0};
                fl_tok.len  = 16'd1;
            end
            M_SLASH: begin
                fl_v        = 1'b1;
                fl_tok.kind = K_SLASH;
                fl_tok.len  = 16'd1;
            end
            M_INT: begin
                fl_v        = 1'b1;
                fl_tok.kind = K_INT;
                fl_tok.ival = r_acc;
            end
            M_IDENT: begin
                fl_v        = 1'b1;
                fl_tok.kind = word_kind(r_prefix, r_lex_len);
                fl_tok.bval = (r_lex_len == 16'd4) && (r_prefix == KW_TRUE);
            end
            M_STRING: begin
                fl_v        = 1'b1;
                fl_tok.kind = K_ERR_STR;
            end
            default: begin
                fl_v = 1'b0;
            end
        endcase
    end

    // Token that a byte gives when it is scanned from idle.
    always_comb begin
        id_v         = 1'b1;
        id_tok       = '0;
        id_tok.start = 16'(r_offset);
        id_tok.len   = 16'd1;
        id_tok.line  = r_line;
        case (r_in_char)
            CH_LPAREN: id_tok.kind = K_LPAREN;
            CH_RPAREN: id_tok.kind = K_RPAREN;
            CH_LBRACE: id_tok.kind = K_LBRACE;
            CH_RBRACE: id_tok.kind = K_RBRACE;
            CH_COMMA:  id_tok.kind = K_COMMA;
            CH_SEMI:   id_tok.kind = K_SEMI;
            CH_PLUS:   id_tok.kind = K_PLUS;
            CH_MINUS:  id_tok.kind = K_MINUS;
            CH_STAR:   id_tok.kind = K_STAR;
            default: begin
                id_tok.kind = K_ERR_CHAR;
                id_v = !(is_blank || is_digit || is_word_start ||
                         r_in_char inside {CH_NL, CH_SLASH, CH_QUOTE, CH_BANG,
                                           CH_EQ, CH_LT, CH_GT});
            end
        endcase
    end

    // Next scanner state and the up to two tokens of the registered item.
    always_comb begin
        n_mode      = r_mode;
        n_pend      = r_pend;
        n_lex_start = r_lex_start;
        n_lex_len   = r_lex_len;
        n_acc       = r_acc;
        n_line      = r_line;
        n_prefix    = r_prefix;
        n_err       = r_err;
        n_offset    = r_offset + OFFSET_BITS'(1);
        do_flush    = 1'b0;
        do_idle     = 1'b0;
        f_v         = 1'b0;
        f_tok       = fl_tok;
        s_v         = 1'b0;
        s_tok       = fl_tok;

        if (r_in_eoi) begin
            // End of input: flush, then end-of-file, then a fresh stream.
            f_v          = fl_v;
            s_v          = 1'b1;
            s_tok        = '0;
            s_tok.kind   = K_EOF;
            s_tok.start  = 16'(r_offset);
            s_tok.line   = r_line;
            s_tok.failed = r_err || (r_mode == M_STRING);
            n_mode       = M_IDLE;
            n_pend       = '0;
            n_lex_start  = '0;
            n_lex_len    = '0;
            n_acc        = '0;
            n_line       = 16'd1;
            n_prefix     = '0;
            n_err        = 1'b0;
            n_offset     = '0;
        end else begin
            case (r_mode)
                M_OP: begin
                    if (r_in_char == CH_EQ) begin
                        s_v        = 1'b1;
                        s_tok.kind = K_BANG_EQ + {3'b0, r_pend, 1'b0};
                        s_tok.len  = 16'd2;
                        n_mode     = M_IDLE;
                    end else begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (r_in_char == CH_SLASH) begin
                        n_mode = M_COMMENT;
                    end else begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (r_in_char == CH_NL) begin
                        n_line = line_inc;
                        n_mode = M_IDLE;
                    end
                end
                M_STRING: begin
                    if (r_in_char == CH_QUOTE) begin
                        s_v        = 1'b1;
                        s_tok.kind = K_STRING;
                        s_tok.len  = len_inc;
                        n_lex_len  = len_inc;
                        n_mode     = M_IDLE;
                    end else if (r_in_char == CH_NL) begin
                        do_flush = 1'b1;
                        n_line   = line_inc;
                        n_mode   = M_IDLE;
                    end else begin
                        n_lex_len = len_inc;
                    end
                end
                M_INT: begin
                    if (is_digit) begin
                        n_acc     = (acc_x10 > {4'b0, INT_MAX}) ? INT_MAX
                                                               : acc_x10[INT_BITS-1:0];
                        n_lex_len = len_inc;
                    end else begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_word_char) begin
                        for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
                            if (r_lex_len == 16'(i)) begin
                                n_prefix[8*i +: 8] = r_in_char;
                            end
                        end
                        n_lex_len = len_inc;
                    end else begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase

            // The ending lexeme's token goes first.
            if (do_flush) begin
                f_v    = fl_v;
                f_tok  = fl_tok;
                n_mode = M_IDLE;
                if (r_mode == M_STRING) begin
                    n_err = 1'b1;
                end
            end

            // The byte itself, scanned as from idle.
            if (do_idle) begin
                n_mode = M_IDLE;
                s_v    = id_v;
                s_tok  = id_tok;
                if (r_in_char == CH_NL) begin
                    n_line = line_inc;
                end else if (!is_blank) begin
                    n_lex_start = r_offset;
                    n_lex_len   = 16'd1;
                    if (r_in_char == CH_SLASH) begin
                        n_mode = M_SLASH;
                    end else if (r_in_char == CH_BANG) begin
                        n_pend = OP_BANG;
                        n_mode = M_OP;
                    end else if (r_in_char == CH_EQ) begin
                        n_pend = OP_EQ;
                        n_mode = M_OP;
                    end else if (r_in_char == CH_LT) begin
                        n_pend = OP_LT;
                        n_mode = M_OP;
                    end else if (r_in_char == CH_GT) begin
                        n_pend = OP_GT;
                        n_mode = M_OP;
                    end else if (r_in_char == CH_QUOTE) begin
                        n_mode = M_STRING;
                    end else if (is_digit) begin
                        n_acc  = {{(INT_BITS-4){1'b0}}, digit};
                        n_mode = M_INT;
                    end else if (is_word_start) begin
                        n_prefix = {{(KW_BITS-8){1'b0}}, r_in_char};
                        n_mode   = M_IDENT;
                    end else if (id_tok.kind == K_ERR_CHAR) begin
                        n_err = 1'b1;
                    end
                end
            end
        end
    end

    // Pack the tokens in order and mark the last one of the item.
    always_comb begin
        t0      = f_v ? f_tok : s_tok;
        t0.last = !(f_v && s_v);
        t1      = s_tok;
        t1.last = 1'b1;
        ntok    = {1'b0, f_v} + {1'b0, s_v};
    end

    // Scanner state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_pend      <= '0;
            r_lex_start <= '0;
            r_lex_len   <= '0;
            r_acc       <= '0;
            r_line      <= 16'd1;
            r_prefix    <= '0;
            r_err       <= 1'b0;
            r_offset    <= '0;
        end else if (proc_fire) begin
            r_mode      <= n_mode;
            r_pend      <= n_pend;
            r_lex_start <= n_lex_start;
            r_lex_len   <= n_lex_len;
            r_acc       <= n_acc;
            r_line      <= n_line;
            r_prefix    <= n_prefix;
            r_err       <= n_err;
            r_offset    <= n_offset;
        end
    end

    // Result register: up to two tokens, the head one on the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_cnt <= 2'd0;
        end else if (proc_fire) begin
            r_res_cnt <= ntok;
        end else if (take) begin
            r_res_cnt <= r_res_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_res[0] <= t0;
            r_res[1] <= t1;
        end else if (take && r_res_cnt == 2'd2) begin
            r_res[0] <= r_res[1];
        end
    end

    // Output channel.
    assign m_axis_tvalid = (r_res_cnt != 2'd0);
    assign m_axis_tlast  = r_res[0].last;
    assign m_axis_tdata  = {{OUT_PAD_BITS{1'b0}}, r_res[0].failed, r_res[0].bval,
                            r_res[0].ival, r_res[0].line, r_res[0].len,
                            r_res[0].start, r_res[0].kind};

    // A pair of tokens shows the first one without the last mark.
    a_pair_head_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_cnt == 2'd2) |-> !r_res[0].last)
        else $error("first token of a pair carries the last mark");

    // A single waiting token is always the last one of its item.
    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_cnt == 2'd1) |-> r_res[0].last)
        else $error("lone waiting token lacks the last mark");

    // The result register never holds more than two tokens.
    a_res_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_cnt != 2'd3)
        else $error("result register count out of range");

    // End of input starts a new stream at line 1, offset 0.
    a_eoi_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_fire && r_in_eoi) |=> (r_line == 16'd1 && r_offset == '0 && !r_err))
        else $error("stream state not restarted after end of input");

    // A waiting input item is not overwritten.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc_fire) |=> (r_in_valid && $stable(r_in_char) &&
                                        $stable(r_in_eoi)))
        else $error("waiting input item was lost");

endmodule
